### rtl/udpf_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the UDP/IPv4 receive filter.
package udpf_pkg;

    // Default frame length limit; the byte offset counter saturates one below it.
    localparam int MAX_FRAME_BYTES_DEF = 2048;

    // Configuration register indexes.
    localparam logic [1:0] CFG_LOCAL_MAC  = 2'd0;
    localparam logic [1:0] CFG_LOCAL_IP   = 2'd1;
    localparam logic [1:0] CFG_LOCAL_PORT = 2'd2;

    // Configuration reset values.
    localparam logic [47:0] LOCAL_MAC_RST  = 48'h0200_0000_0001;
    localparam logic [31:0] LOCAL_IP_RST   = 32'h0A0A_0A0A;
    localparam logic [15:0] LOCAL_PORT_RST = 16'h0001;

    // Header byte offsets in the frame.
    localparam int POS_MAC_LAST   = 5;
    localparam int POS_ETYPE_HI   = 12;
    localparam int POS_ETYPE_LO   = 13;
    localparam int POS_VER_IHL    = 14;
    localparam int POS_IPLEN_HI   = 16;
    localparam int POS_IPLEN_LO   = 17;
    localparam int POS_PROTO      = 23;
    localparam int POS_SRCIP_FST  = 26;
    localparam int POS_SRCIP_LST  = 29;
    localparam int POS_DSTIP_FST  = 30;
    localparam int POS_DSTIP_LST  = 33;
    localparam int POS_SPORT_HI   = 34;
    localparam int POS_SPORT_LO   = 35;
    localparam int POS_DPORT_HI   = 36;
    localparam int POS_DPORT_LO   = 37;
    localparam int POS_ULEN_HI    = 38;
    localparam int POS_ULEN_LO    = 39;
    localparam int POS_HDR_LAST   = 41;

    // Header field values.
    localparam logic [7:0]  BCAST_BYTE    = 8'hFF;
    localparam logic [7:0]  ETYPE_IPV4_HI = 8'h08;
    localparam logic [7:0]  ETYPE_IPV4_LO = 8'h00;
    localparam logic [7:0]  VER_IHL_IPV4  = 8'h45;
    localparam logic [7:0]  PROTO_UDP     = 8'd17;
    localparam logic [15:0] IP_LEN_MIN    = 16'd28;
    localparam logic [15:0] UDP_HDR_LEN   = 16'd8;

    // One result beat.
    typedef struct packed {
        logic [7:0]  payload_byte;
        logic        byte_present;
        logic [31:0] sender_ip;
        logic [15:0] sender_port;
        logic [15:0] payload_length;
        logic        final_byte;
        logic        truncated;
    } t_result;

endpackage

### rtl/udp_ipv4_receive_filter.sv
`timescale 1ns / 1ps
// Top level: Ethernet/IPv4/UDP receive filter with payload extraction.
//
//  Channel  | Direction | Handshake                  | Beat
//  ---------+-----------+----------------------------+-------------------------------------
//  in       | in        | i_in_valid / o_in_stall    | one frame byte plus end-of-frame flag
//  out      | out       | o_out_valid / i_out_stall  | one payload byte with datagram info
//  cfg      | in        | i_cfg_valid / o_cfg_ready  | register index plus write data
//
// One frame byte is taken per cycle while o_in_stall is low; its header check,
// field capture and payload decision are done in the same cycle and the result
// lands in the output register, or in the skid register while the output is stalled.
// A two-entry output (output register plus skid register) absorbs a stall;
// o_in_stall is raised only while the skid register holds a beat.
// Reset (i_rst_n low, synchronous) restores the configuration defaults and
// empties the frame state and the output stage; no clearing pass is needed.
module udp_ipv4_receive_filter #(
    parameter int MAX_FRAME_BYTES = udpf_pkg::MAX_FRAME_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // frame byte stream
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_frame_byte,
    input  logic        i_frame_end,
    // payload result stream
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_payload_byte,
    output logic        o_byte_present,
    output logic [31:0] o_sender_ip,
    output logic [15:0] o_sender_port,
    output logic [15:0] o_payload_length,
    output logic        o_final_byte,
    output logic        o_truncated,
    // configuration writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [47:0] i_cfg_data
);
    import udpf_pkg::*;

    localparam int POS_W = $clog2(MAX_FRAME_BYTES);
    localparam logic [POS_W-1:0] POS_SAT = POS_W'(MAX_FRAME_BYTES - 1);

    // configuration
    logic [47:0] r_local_mac;
    logic [31:0] r_local_ip;
    logic [15:0] r_local_port;

    // frame state
    logic [POS_W-1:0] r_pos,       n_pos;
    logic             r_rejected,  n_rejected;
    logic             r_mac_mm,    n_mac_mm;
    logic             r_bcast,     n_bcast;
    logic [31:0]      r_src_ip,    n_src_ip;
    logic [15:0]      r_sport,     n_sport;
    logic [7:0]       r_iplen_hi,  n_iplen_hi;
    logic [7:0]       r_ulen_hi,   n_ulen_hi;
    logic [15:0]      r_pay_len,   n_pay_len;
    logic [15:0]      r_left,      n_left;
    logic             r_finished,  n_finished;

    // output stage
    logic    r_out_valid;
    logic    r_skid_valid;
    t_result r_out;
    t_result r_skid;

    logic    in_fire;
    logic    out_fire;
    logic    emit;
    t_result res;
    logic [7:0]  mac_byte;
    logic [7:0]  ip_byte;
    logic [1:0]  ip_sel;
    logic [15:0] ulen;
    logic [15:0] iplen;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = r_skid_valid;
    assign in_fire     = i_in_valid && !r_skid_valid;
    assign out_fire    = r_out_valid && !i_out_stall;

    // Configuration registers: take each write at once.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_local_mac  <= LOCAL_MAC_RST;
            r_local_ip   <= LOCAL_IP_RST;
            r_local_port <= LOCAL_PORT_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_LOCAL_MAC:  r_local_mac  <= i_cfg_data;
                CFG_LOCAL_IP:   r_local_ip   <= i_cfg_data[31:0];
                CFG_LOCAL_PORT: r_local_port <= i_cfg_data[15:0];
                default: ;  // unmapped index: ignore the write
            endcase
        end
    end

    // Expected destination MAC byte for offsets 0..5.
    always_comb begin
        unique case (r_pos[2:0])
            3'd0:    mac_byte = r_local_mac[47:40];
            3'd1:    mac_byte = r_local_mac[39:32];
            3'd2:    mac_byte = r_local_mac[31:24];
            3'd3:    mac_byte = r_local_mac[23:16];
            3'd4:    mac_byte = r_local_mac[15:8];
            3'd5:    mac_byte = r_local_mac[7:0];
            default: mac_byte = 8'h00;
        endcase
    end

    // Expected destination IP byte for offsets 30..33 (low bits 2,3,0,1).
    assign ip_sel = r_pos[1:0] + 2'd2;
    always_comb begin
        unique case (ip_sel)
            2'd0:    ip_byte = r_local_ip[31:24];
            2'd1:    ip_byte = r_local_ip[23:16];
            2'd2:    ip_byte = r_local_ip[15:8];
            default: ip_byte = r_local_ip[7:0];
        endcase
    end

    assign ulen  = {r_ulen_hi, i_frame_byte};
    assign iplen = {r_iplen_hi, i_frame_byte};

    // Per-byte header check, field capture and payload decision.
    always_comb begin
        n_pos      = r_pos;
        n_rejected = r_rejected;
        n_mac_mm   = r_mac_mm;
        n_bcast    = r_bcast;
        n_src_ip   = r_src_ip;
        n_sport    = r_sport;
        n_iplen_hi = r_iplen_hi;
        n_ulen_hi  = r_ulen_hi;
        n_pay_len  = r_pay_len;
        n_left     = r_left;
        n_finished = r_finished;
        emit       = 1'b0;

        res.payload_byte   = 8'h00;
        res.byte_present   = 1'b0;
        res.sender_ip      = r_src_ip;
        res.sender_port    = r_sport;
        res.payload_length = r_pay_len;
        res.final_byte     = 1'b0;
        res.truncated      = 1'b0;

        priority if (r_pos <= POS_W'(POS_MAC_LAST)) begin
            if (r_pos == '0 && i_frame_byte == BCAST_BYTE) begin
                n_bcast = 1'b1;
            end
            if (i_frame_byte != mac_byte) begin
                n_mac_mm = 1'b1;
            end
            // broadcast flag is already registered by the last MAC byte
            if (r_pos == POS_W'(POS_MAC_LAST) && n_mac_mm && !r_bcast) begin
                n_rejected = 1'b1;
            end
        end else if (r_pos == POS_W'(POS_ETYPE_HI)) begin
            if (i_frame_byte != ETYPE_IPV4_HI) n_rejected = 1'b1;
        end else if (r_pos == POS_W'(POS_ETYPE_LO)) begin
            if (i_frame_byte != ETYPE_IPV4_LO) n_rejected = 1'b1;
        end else if (r_pos == POS_W'(POS_VER_IHL)) begin
            if (i_frame_byte != VER_IHL_IPV4) n_rejected = 1'b1;
        end else if (r_pos == POS_W'(POS_IPLEN_HI)) begin
            n_iplen_hi = i_frame_byte;
        end else if (r_pos == POS_W'(POS_IPLEN_LO)) begin
            if (iplen < IP_LEN_MIN) n_rejected = 1'b1;
        end else if (r_pos == POS_W'(POS_PROTO)) begin
            if (i_frame_byte != PROTO_UDP) n_rejected = 1'b1;
        end else if (r_pos >= POS_W'(POS_SRCIP_FST) && r_pos <= POS_W'(POS_SRCIP_LST)) begin
            n_src_ip = {r_src_ip[23:0], i_frame_byte};
        end else if (r_pos >= POS_W'(POS_DSTIP_FST) && r_pos <= POS_W'(POS_DSTIP_LST)) begin
            if (i_frame_byte != ip_byte) n_rejected = 1'b1;
        end else if (r_pos == POS_W'(POS_SPORT_HI) || r_pos == POS_W'(POS_SPORT_LO)) begin
            n_sport = {r_sport[7:0], i_frame_byte};
        end else if (r_pos == POS_W'(POS_DPORT_HI)) begin
            if (i_frame_byte != r_local_port[15:8]) n_rejected = 1'b1;
        end else if (r_pos == POS_W'(POS_DPORT_LO)) begin
            if (i_frame_byte != r_local_port[7:0]) n_rejected = 1'b1;
        end else if (r_pos == POS_W'(POS_ULEN_HI)) begin
            n_ulen_hi = i_frame_byte;
        end else if (r_pos == POS_W'(POS_ULEN_LO)) begin
            // payload length is latched even when the datagram is rejected
            n_pay_len = ulen - UDP_HDR_LEN;
            if (ulen < UDP_HDR_LEN) begin
                n_rejected = 1'b1;
            end else begin
                n_left = ulen - UDP_HDR_LEN;
            end
        end else if (r_pos == POS_W'(POS_HDR_LAST)) begin
            // last header byte: empty datagram, or header-only truncated frame
            if (!r_rejected && (r_left == '0 || i_frame_end)) begin
                emit           = 1'b1;
                res.final_byte = 1'b1;
                res.truncated  = (r_left != '0);
                n_finished     = 1'b1;
            end
        end else if (r_pos > POS_W'(POS_HDR_LAST)) begin
            if (!r_rejected && !r_finished && r_left != '0) begin
                n_left           = r_left - 16'd1;
                emit             = 1'b1;
                res.payload_byte = i_frame_byte;
                res.byte_present = 1'b1;
                res.final_byte   = (n_left == '0) || i_frame_end;
                res.truncated    = i_frame_end && (n_left != '0);
                n_finished       = res.final_byte;
            end
        end else begin
            // skipped header bytes
        end

        if (i_frame_end) begin
            n_pos      = '0;
            n_rejected = 1'b0;
            n_mac_mm   = 1'b0;
            n_bcast    = 1'b0;
            n_left     = '0;
            n_finished = 1'b0;
        end else if (r_pos < POS_SAT) begin
            n_pos = r_pos + POS_W'(1);
        end
    end

    // Frame state: advance only on an accepted beat.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_rejected <= 1'b0;
            r_mac_mm   <= 1'b0;
            r_bcast    <= 1'b0;
            r_left     <= '0;
            r_finished <= 1'b0;
        end else if (in_fire) begin
            r_pos      <= n_pos;
            r_rejected <= n_rejected;
            r_mac_mm   <= n_mac_mm;
            r_bcast    <= n_bcast;
            r_left     <= n_left;
            r_finished <= n_finished;
        end
    end

    // Captured header fields: every emitted result follows their capture.
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_src_ip   <= n_src_ip;
            r_sport    <= n_sport;
            r_iplen_hi <= n_iplen_hi;
            r_ulen_hi  <= n_ulen_hi;
            r_pay_len  <= n_pay_len;
        end
    end

    // Output register plus skid register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || out_fire) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= in_fire && emit;
            end
        end else if (in_fire && emit) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || out_fire) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (in_fire && emit) begin
                r_out <= res;
            end
        end else if (in_fire && emit) begin
            r_skid <= res;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_payload_byte   = r_out.payload_byte;
    assign o_byte_present   = r_out.byte_present;
    assign o_sender_ip      = r_out.sender_ip;
    assign o_sender_port    = r_out.sender_port;
    assign o_payload_length = r_out.payload_length;
    assign o_final_byte     = r_out.final_byte;
    assign o_truncated      = r_out.truncated;

endmodule

### rtl/udpf_check.sv
`timescale 1ns / 1ps
// Port-level assertions for the UDP/IPv4 receive filter, with bind.
module udpf_check (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [7:0]  o_payload_byte,
    input logic        o_byte_present,
    input logic [31:0] o_sender_ip,
    input logic        o_final_byte,
    input logic        o_truncated
);

    // A stalled result beat holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_payload_byte)
            && $stable(o_sender_ip) && $stable(o_final_byte))
        else $error("stalled result beat changed");

    // Input stall only comes up behind a stalled output.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_in_stall) |-> $past(o_out_valid && i_out_stall))
        else $error("input stall without output backpressure");

    // An empty result always closes the datagram.
    a_empty_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_byte_present |-> o_final_byte && o_payload_byte == 8'h00)
        else $error("empty result not final or carries data");

    // Truncation is only flagged on the closing beat.
    a_trunc_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_truncated |-> o_final_byte)
        else $error("truncated flag on non-final beat");

endmodule

bind udp_ipv4_receive_filter udpf_check u_udpf_check (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_in_stall     (o_in_stall),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_payload_byte (o_payload_byte),
    .o_byte_present (o_byte_present),
    .o_sender_ip    (o_sender_ip),
    .o_final_byte   (o_final_byte),
    .o_truncated    (o_truncated)
);

### test/udp_rx_scoreboard_pkg.sv
`timescale 1ns / 1ps
// Scoreboard for the UDP receive filter: header tracking, payload prediction, beat compare.
package udp_rx_scoreboard_pkg;

    import udpf_pkg::*;

    class t_udp_rx_scoreboard;
        // register copies
        logic [47:0] own_mac;
        logic [31:0] own_ip;
        logic [15:0] own_port;
        // per-frame state
        logic [11:0] position;
        bit          rejected;
        bit          mac_miss;
        bit          bcast;
        bit          done;
        logic [15:0] left;
        // captured header fields, kept across frames
        logic [31:0] src_ip;
        logic [15:0] sport;
        logic [15:0] ip_len;
        logic [15:0] udp_len;
        t_result     pending[$];
        int          errors;

        function new();
            own_mac  = LOCAL_MAC_RST;
            own_ip   = LOCAL_IP_RST;
            own_port = LOCAL_PORT_RST;
            src_ip   = '0;
            sport    = '0;
            ip_len   = '0;
            udp_len  = '0;
            errors   = 0;
            clear_frame();
        endfunction

        function void clear_frame();
            position = '0;
            rejected = 1'b0;
            mac_miss = 1'b0;
            bcast    = 1'b0;
            left     = '0;
            done     = 1'b0;
        endfunction

        function void set_reg(input logic [1:0] idx, input logic [47:0] value);
            case (idx)
                CFG_LOCAL_MAC:  own_mac  = value;
                CFG_LOCAL_IP:   own_ip   = value[31:0];
                CFG_LOCAL_PORT: own_port = value[15:0];
                default: ;
            endcase
        endfunction

        function void expect_beat(input logic [7:0] b, input bit present, input bit fin,
                                  input bit trunc);
            t_result r;
            r.payload_byte   = present ? b : 8'h00;
            r.byte_present   = present;
            r.sender_ip      = src_ip;
            r.sender_port    = sport;
            r.payload_length = udp_len - UDP_HDR_LEN;
            r.final_byte     = fin;
            r.truncated      = trunc;
            pending.push_back(r);
        endfunction

        // Advance the header walk by one accepted byte; queue the result it causes.
        function void take_byte(input logic [7:0] b, input logic last);
            int p;
            bit fin;
            p = int'(position);
            if (p <= POS_MAC_LAST) begin
                if (p == 0 && b == BCAST_BYTE) bcast = 1'b1;
                if (b != own_mac[47 - 8 * p -: 8]) mac_miss = 1'b1;
                if (p == POS_MAC_LAST && mac_miss && !bcast) rejected = 1'b1;
            end else if (p == POS_ETYPE_HI) begin
                if (b != ETYPE_IPV4_HI) rejected = 1'b1;
            end else if (p == POS_ETYPE_LO) begin
                if (b != ETYPE_IPV4_LO) rejected = 1'b1;
            end else if (p == POS_VER_IHL) begin
                if (b != VER_IHL_IPV4) rejected = 1'b1;
            end else if (p == POS_IPLEN_HI || p == POS_IPLEN_LO) begin
                ip_len = {ip_len[7:0], b};
                if (p == POS_IPLEN_LO && ip_len < IP_LEN_MIN) rejected = 1'b1;
            end else if (p == POS_PROTO) begin
                if (b != PROTO_UDP) rejected = 1'b1;
            end else if (p >= POS_SRCIP_FST && p <= POS_SRCIP_LST) begin
                src_ip = {src_ip[23:0], b};
            end else if (p >= POS_DSTIP_FST && p <= POS_DSTIP_LST) begin
                if (b != own_ip[31 - 8 * (p - POS_DSTIP_FST) -: 8]) rejected = 1'b1;
            end else if (p == POS_SPORT_HI || p == POS_SPORT_LO) begin
                sport = {sport[7:0], b};
            end else if (p == POS_DPORT_HI) begin
                if (b != own_port[15:8]) rejected = 1'b1;
            end else if (p == POS_DPORT_LO) begin
                if (b != own_port[7:0]) rejected = 1'b1;
            end else if (p == POS_ULEN_HI || p == POS_ULEN_LO) begin
                udp_len = {udp_len[7:0], b};
                if (p == POS_ULEN_LO) begin
                    if (udp_len < UDP_HDR_LEN) rejected = 1'b1;
                    else left = udp_len - UDP_HDR_LEN;
                end
            end else if (p == POS_HDR_LAST) begin
                // empty datagram, or header-only frame that still owed payload
                if (!rejected && (left == 0 || last)) begin
                    expect_beat(8'h00, 1'b0, 1'b1, left != 0);
                    done = 1'b1;
                end
            end else if (p > POS_HDR_LAST) begin
                if (!rejected && !done && left != 0) begin
                    left = left - 16'd1;
                    fin  = (left == 0) || last;
                    expect_beat(b, 1'b1, fin, last && left != 0);
                    if (fin) done = 1'b1;
                end
            end
            if (last) clear_frame();
            else if (position < MAX_FRAME_BYTES_DEF - 1) position = position + 12'd1;
        endfunction

        function void compare(input string name, input logic [31:0] want,
                              input logic [31:0] got);
            if (want !== got) begin
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_beat(input t_result got);
            t_result want;
            if (pending.size() == 0) begin
                $display("%0t: unexpected beat, expected none, actual byte %0h ip %0h port %0h",
                         $time, got.payload_byte, got.sender_ip, got.sender_port);
                errors++;
                return;
            end
            want = pending.pop_front();
            compare("payload_byte", want.payload_byte, got.payload_byte);
            compare("byte_present", want.byte_present, got.byte_present);
            compare("sender_ip", want.sender_ip, got.sender_ip);
            compare("sender_port", want.sender_port, got.sender_port);
            compare("payload_length", want.payload_length, got.payload_length);
            compare("final_byte", want.final_byte, got.final_byte);
            compare("truncated", want.truncated, got.truncated);
        endfunction
    endclass

endpackage

### test/udp_ipv4_receive_filter_tb.sv
`timescale 1ns / 1ps
// Testbench top: drives frames and register writes into the UDP receive filter and checks beats.
module udp_ipv4_receive_filter_tb;

    import udpf_pkg::*;
    import udp_rx_scoreboard_pkg::*;

    // Index that maps to no register; writes to it must be ignored.
    localparam logic [1:0] CFG_UNUSED = 2'd3;

    // Header fields that the frame builder places at their fixed offsets.
    typedef struct packed {
        logic [47:0] dst_mac;
        logic [15:0] etype;
        logic [7:0]  ver_ihl;
        logic [15:0] ip_len;
        logic [7:0]  proto;
        logic [31:0] src_ip;
        logic [31:0] dst_ip;
        logic [15:0] sport;
        logic [15:0] dport;
        logic [15:0] udp_len;
    } t_udp_hdr;

    localparam int HDR_W = $bits(t_udp_hdr);

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [7:0]  i_frame_byte;
    logic        i_frame_end;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [7:0]  o_payload_byte;
    logic        o_byte_present;
    logic [31:0] o_sender_ip;
    logic [15:0] o_sender_port;
    logic [15:0] o_payload_length;
    logic        o_final_byte;
    logic        o_truncated;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [47:0] i_cfg_data;

    t_result            out_beat;
    t_udp_rx_scoreboard sb;
    // Gap enables for the sender and the receiver; cleared for the closing stretch.
    bit                 tx_gaps_on = 1'b0;
    bit                 rx_gaps_on = 1'b0;

    udp_ipv4_receive_filter dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_frame_byte    (i_frame_byte),
        .i_frame_end     (i_frame_end),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_payload_byte  (o_payload_byte),
        .o_byte_present  (o_byte_present),
        .o_sender_ip     (o_sender_ip),
        .o_sender_port   (o_sender_port),
        .o_payload_length(o_payload_length),
        .o_final_byte    (o_final_byte),
        .o_truncated     (o_truncated),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    // 10 ns clock.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Hard stop: well beyond the slowest legal run with the longest stall bursts.
    initial begin
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // Pack the result ports in the package's field order.
    assign out_beat = {o_payload_byte, o_byte_present, o_sender_ip, o_sender_port,
                       o_payload_length, o_final_byte, o_truncated};

    // Check every beat that leaves the block. Sampling at the edge sees the values
    // from before the edge, so the order of processes in this step does not matter.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) sb.check_beat(out_beat);
    end

    // Receiver back-pressure: random stall bursts while enabled.
    // Always wait for a clock edge after a release so the stall never drops and rises
    // within the same step.
    initial begin
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (rx_gaps_on && $urandom_range(0, 7) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 17)) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    function automatic logic [47:0] rand48();
        return 48'({$urandom, $urandom});
    endfunction

    // A header that passes every test against the current register copies.
    function automatic t_udp_hdr matching_hdr(input int n_payload);
        t_udp_hdr h;
        h.dst_mac  = sb.own_mac;
        h.etype    = {ETYPE_IPV4_HI, ETYPE_IPV4_LO};
        h.ver_ihl  = VER_IHL_IPV4;
        h.ip_len   = 16'($urandom_range(IP_LEN_MIN, 16'hFFFF));
        h.proto    = PROTO_UDP;
        h.src_ip   = $urandom;
        h.dst_ip   = sb.own_ip;
        h.sport    = 16'($urandom);
        h.dport    = sb.own_port;
        h.udp_len  = UDP_HDR_LEN + 16'(n_payload);
        return h;
    endfunction

    // Byte at a given frame offset: header field where one sits, random filler elsewhere.
    function automatic logic [7:0] frame_octet(input t_udp_hdr h, input int off);
        if (off <= POS_MAC_LAST) return h.dst_mac[47 - 8 * off -: 8];
        if (off == POS_ETYPE_HI) return h.etype[15:8];
        if (off == POS_ETYPE_LO) return h.etype[7:0];
        if (off == POS_VER_IHL) return h.ver_ihl;
        if (off == POS_IPLEN_HI) return h.ip_len[15:8];
        if (off == POS_IPLEN_LO) return h.ip_len[7:0];
        if (off == POS_PROTO) return h.proto;
        if (off >= POS_SRCIP_FST && off <= POS_SRCIP_LST)
            return h.src_ip[31 - 8 * (off - POS_SRCIP_FST) -: 8];
        if (off >= POS_DSTIP_FST && off <= POS_DSTIP_LST)
            return h.dst_ip[31 - 8 * (off - POS_DSTIP_FST) -: 8];
        if (off == POS_SPORT_HI) return h.sport[15:8];
        if (off == POS_SPORT_LO) return h.sport[7:0];
        if (off == POS_DPORT_HI) return h.dport[15:8];
        if (off == POS_DPORT_LO) return h.dport[7:0];
        if (off == POS_ULEN_HI) return h.udp_len[15:8];
        if (off == POS_ULEN_LO) return h.udp_len[7:0];
        return 8'($urandom);
    endfunction

    // Send one frame byte. Optionally open a gap first; hold the beat until it is
    // taken, then note it in the scoreboard. Valid stays high into the next beat.
    task automatic push_byte(input logic [7:0] b, input logic last);
        if (tx_gaps_on && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_frame_byte <= b;
        i_frame_end  <= last;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.take_byte(b, last);
    endtask

    task automatic send_udp(input t_udp_hdr h, input int len);
        for (int i = 0; i < len; i++) push_byte(frame_octet(h, i), i == len - 1);
    endtask

    // Drop valid and hold off until every queued result has come out.
    task automatic drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending.size() != 0);
    endtask

    // Drain, then let the pipe run dry before touching registers.
    task automatic settle();
        drain();
        repeat (8) @(posedge i_clk);
    endtask

    // Leave valid high on return so back-to-back writes keep one assignment per step.
    task automatic write_reg(input logic [1:0] idx, input logic [47:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_reg(idx, value);
    endtask

    // Write all three registers, with junk in the unused upper data bits,
    // plus one write to the unmapped index.
    task automatic set_config(input logic [47:0] mac, input logic [31:0] ip,
                              input logic [15:0] port);
        logic [47:0] junk;
        junk = rand48();
        write_reg(CFG_LOCAL_MAC, mac);
        write_reg(CFG_LOCAL_IP, {junk[47:32], ip});
        write_reg(CFG_LOCAL_PORT, {junk[47:16], port});
        write_reg(CFG_UNUSED, rand48());
        i_cfg_valid <= 1'b0;
    endtask

    // Random frames until about `goal` bytes of real traffic have gone in. Most
    // frames pass the filter with random payload, padding or early end; the rest
    // carry one broken header field, end inside the header, or are plain noise.
    task automatic random_frames(input int goal, input bit allow_gaps);
        t_udp_hdr h;
        int       n;
        int       len;
        int       kind;
        int       sel;
        int       bitx;
        int       counted;
        counted = 0;
        while (counted < goal) begin
            tx_gaps_on = allow_gaps && ($urandom_range(0, 3) != 0);
            rx_gaps_on = allow_gaps && ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 19) == 0) drain();
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 200) : $urandom_range(0, 24);
            h = matching_hdr(n);
            if ($urandom_range(0, 3) == 0) begin
                h.dst_mac[39:0]  = 40'(rand48());
                h.dst_mac[47:40] = BCAST_BYTE;
            end
            len  = POS_HDR_LAST + 1 + n;
            kind = $urandom_range(0, 99);
            sel  = $urandom_range(0, 9);
            bitx = $urandom_range(0, 7);
            if (kind < 15) begin
                len += $urandom_range(1, 10);
            end else if (kind < 30) begin
                len = $urandom_range(POS_HDR_LAST + 1, len);
            end else if (kind < 45) begin
                case (sel)
                    0: h.dst_mac[8 * $urandom_range(0, 5) + bitx] ^= 1'b1;
                    1: h.etype[8 + bitx] ^= 1'b1;
                    2: h.etype[bitx] ^= 1'b1;
                    3: h.ver_ihl[bitx] ^= 1'b1;
                    4: h.ip_len = 16'($urandom_range(0, IP_LEN_MIN - 1));
                    5: h.proto[bitx] ^= 1'b1;
                    6: h.dst_ip[8 * $urandom_range(0, 3) + bitx] ^= 1'b1;
                    7: h.dport[8 + bitx] ^= 1'b1;
                    8: h.dport[bitx] ^= 1'b1;
                    default: h.udp_len = 16'($urandom_range(0, UDP_HDR_LEN - 1));
                endcase
            end else if (kind < 55) begin
                len = $urandom_range(1, POS_HDR_LAST);
            end else if (kind < 60) begin
                h   = HDR_W'({$urandom, $urandom, $urandom, $urandom,
                              $urandom, $urandom, $urandom, $urandom});
                len = $urandom_range(1, 60);
            end
            send_udp(h, len);
            if (kind < 55 || kind >= 60) counted += len;
        end
    endtask

    initial begin
        t_udp_hdr h;
        sb = new();
        i_rst_n      <= 1'b0;
        i_in_valid   <= 1'b0;
        i_frame_byte <= 8'h00;
        i_frame_end  <= 1'b0;
        i_cfg_valid  <= 1'b0;
        i_cfg_index  <= CFG_LOCAL_MAC;
        i_cfg_data   <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed frames against the reset register values.
        tx_gaps_on = 1'b1;
        rx_gaps_on = 1'b1;
        send_udp(matching_hdr(4), 46);                    // exact length
        send_udp(matching_hdr(0), 42);                    // empty datagram
        send_udp(matching_hdr(12), 42);                   // ends right after the header
        send_udp(matching_hdr(10), 47);                   // ends inside the payload
        h = matching_hdr(3);
        h.dst_mac = {BCAST_BYTE, 40'h0};                  // broadcast, rest all zero
        send_udp(h, 45);
        send_udp(matching_hdr(2), 1);                     // short frames: dropped
        send_udp(matching_hdr(2), 20);

        // Random traffic across several register settings, extremes included.
        settle();
        set_config(rand48(), $urandom, 16'($urandom));
        random_frames(55, 1'b1);
        settle();
        set_config(48'h0, 32'h0, 16'h0);
        random_frames(55, 1'b1);
        settle();
        set_config('1, '1, '1);
        random_frames(55, 1'b1);
        settle();
        set_config(rand48(), $urandom, 16'($urandom));
        random_frames(55, 1'b0);                          // closing stretch, no gaps

        settle();
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

### udp_ipv4_receive_filter.f
rtl/udpf_pkg.sv
rtl/udp_ipv4_receive_filter.sv
rtl/udpf_check.sv
test/udp_rx_scoreboard_pkg.sv
test/udp_ipv4_receive_filter_tb.sv
